// ===== src/fragment_reassembly_buffer_defines.svh =====
// assertion macros shared by the reassembly buffer modules
// each use expects clk and rst_n in scope
`ifndef FRAGMENT_REASSEMBLY_BUFFER_DEFINES_SVH
`define FRAGMENT_REASSEMBLY_BUFFER_DEFINES_SVH

`ifndef SYNTHESIS

// condition holds at every clock edge out of reset
`define FRB_ASSERT(lbl, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// precondition implies the consequence in the next cycle
`define FRB_ASSERT_NEXT(lbl, pre, post, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error(msg);

`else

`define FRB_ASSERT(lbl, cond, msg)
`define FRB_ASSERT_NEXT(lbl, pre, post, msg)

`endif

`endif

// ===== src/frb_pkg.sv =====
package frb_pkg;

    localparam int MAX_FRAGS       = 16;
    localparam int MAX_FRAG_BYTES  = 256;
    localparam int MAX_FRAME_BYTES = 4096;

    // derived widths
    localparam int IDX_W      = (MAX_FRAGS > 1) ? $clog2(MAX_FRAGS) : 1;
    localparam int CS_W       = $clog2(MAX_FRAGS + 1);
    localparam int CNT_W      = 7;
    localparam int WP_W       = $clog2(MAX_FRAG_BYTES + 1);
    localparam int SLOT_DEPTH = MAX_FRAGS * MAX_FRAG_BYTES;
    localparam int SA_W       = (SLOT_DEPTH > 1) ? $clog2(SLOT_DEPTH) : 1;
    localparam int FA_W       = $clog2(MAX_FRAME_BYTES);
    localparam int TOT_W      = $clog2(SLOT_DEPTH + 1);

    // status codes
    localparam logic [3:0] STAT_STORED     = 4'd0;
    localparam logic [3:0] STAT_DUPLICATE  = 4'd1;
    localparam logic [3:0] STAT_BAD_HEADER = 4'd2;
    localparam logic [3:0] STAT_NO_FRAME   = 4'd3;
    localparam logic [3:0] STAT_COMPLETE   = 4'd4;
    localparam logic [3:0] STAT_TOO_LARGE  = 4'd5;
    localparam logic [3:0] STAT_TOO_LONG   = 4'd6;
    localparam logic [3:0] STAT_READ_OK    = 4'd7;
    localparam logic [3:0] STAT_BEYOND     = 4'd8;

    typedef struct packed {
        logic        req_type;
        logic [7:0]  frag_index;
        logic [7:0]  frag_count;
        logic [7:0]  data_byte;
        logic        byte_last;
        logic [11:0] read_offset;
    } in_t;

    typedef struct packed {
        logic [3:0]  status;
        logic [12:0] frame_length;
        logic [7:0]  read_data;
        logic [6:0]  frags_stored;
    } out_t;

    // classified item passed from front to back
    typedef struct packed {
        logic        is_read;
        logic        last;
        logic        hdr_ok;
        logic        idx_zero;
        logic [7:0]  frag_index;
        logic [7:0]  frag_count;
        logic [7:0]  data_byte;
        logic [11:0] read_offset;
    } cmd_t;

endpackage

// ===== src/fragment_reassembly_buffer.sv =====
// Fragment reassembly buffer: items carry either one fragment byte or a read request. An item
// is taken when start is high and busy is low; a two-entry queue stands in front of the
// executing logic, so items normally flow at one per cycle. Each fragment's last byte and each
// read give exactly one result, shown with done for a single cycle in the cycle after the item
// leaves the queue; the receiver must take it then. When a fragment completes its frame, the
// slots are copied into the frame store one byte per cycle, so the block holds further items
// in the queue (and raises busy once it is full) until the copy ends. Read results come from
// the frame store's registered read port.
module fragment_reassembly_buffer (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  frb_pkg::in_t  cmd,
    output logic          busy,
    output logic          done,
    output frb_pkg::out_t result
);
    import frb_pkg::*;

    cmd_t head;
    logic head_valid;
    logic pop;

    frb_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .cmd        (cmd),
        .busy       (busy),
        .head       (head),
        .head_valid (head_valid),
        .pop        (pop)
    );

    frb_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head       (head),
        .head_valid (head_valid),
        .pop        (pop),
        .done       (done),
        .result     (result)
    );

endmodule

// ===== src/frb_ram.sv =====
module frb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                     clk,
    input  logic                                     we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                         wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    // one write port, registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata <= mem_reg[raddr];
    end

endmodule

// ===== src/frb_front.sv =====
`include "fragment_reassembly_buffer_defines.svh"

module frb_front (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         start,
    input  frb_pkg::in_t cmd,
    output logic         busy,
    output frb_pkg::cmd_t head,
    output logic         head_valid,
    input  logic         pop
);
    import frb_pkg::*;

    cmd_t       q_reg [2];
    logic       wr_ptr_reg;
    logic       wr_ptr_next;
    logic       rd_ptr_reg;
    logic       rd_ptr_next;
    logic [1:0] count_reg;
    logic [1:0] count_next;
    logic       push;
    cmd_t       cls;

    // header check and item classification
    always_comb
    begin
        cls.is_read     = cmd.req_type;
        cls.last        = cmd.byte_last;
        cls.hdr_ok      = (cmd.frag_count != 8'd0)
                          && (32'(cmd.frag_count) <= 32'(MAX_FRAGS))
                          && (cmd.frag_index < cmd.frag_count);
        cls.idx_zero    = (cmd.frag_index == 8'd0);
        cls.frag_index  = cmd.frag_index;
        cls.frag_count  = cmd.frag_count;
        cls.data_byte   = cmd.data_byte;
        cls.read_offset = cmd.read_offset;
    end

    assign busy       = (count_reg == 2'd2);
    assign push       = start && !busy;
    assign head       = q_reg[rd_ptr_reg];
    assign head_valid = (count_reg != 2'd0);

    // two-entry queue pointers
    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // queue storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_reg[wr_ptr_reg] <= cls;
        end
    end

    `FRB_ASSERT(a_count_bound, count_reg != 2'd3, "queue count beyond depth")
    `FRB_ASSERT_NEXT(a_pop_nonempty, pop && !push && count_reg == 2'd1, count_reg == 2'd0, "queue count lost an item")

endmodule

// ===== src/frb_back.sv =====
`include "fragment_reassembly_buffer_defines.svh"

module frb_back (
    input  logic          clk,
    input  logic          rst_n,
    input  frb_pkg::cmd_t head,
    input  logic          head_valid,
    output logic          pop,
    output logic          done,
    output frb_pkg::out_t result
);
    import frb_pkg::*;

    typedef enum logic [1:0] {
        ST_RUN  = 2'b01,
        ST_COPY = 2'b10
    } state_t;

    state_t               state_reg, state_next;
    logic [MAX_FRAGS-1:0] filled_reg, filled_next;
    logic [WP_W-1:0]      len_reg [MAX_FRAGS];
    logic [WP_W-1:0]      len_next [MAX_FRAGS];
    logic [WP_W-1:0]      wp_reg, wp_next;
    logic                 ovl_reg, ovl_next;
    logic [CNT_W-1:0]     stored_reg, stored_next;
    logic [CNT_W-1:0]     expected_reg, expected_next;
    logic [TOT_W-1:0]     total_reg, total_next;
    logic [TOT_W-1:0]     frame_bytes_reg, frame_bytes_next;
    logic [CS_W-1:0]      cs_reg, cs_next;
    logic [WP_W-1:0]      cb_reg, cb_next;
    logic [FA_W-1:0]      pos_reg, pos_next;
    logic                 cp_we_reg, cp_we_next;
    logic [FA_W-1:0]      cp_addr_reg, cp_addr_next;
    logic                 done_reg, done_next;
    logic [3:0]           stat_reg, stat_next;
    logic [12:0]          flen_reg, flen_next;
    logic [CNT_W-1:0]     frags_reg, frags_next;
    logic                 rd_sel_reg, rd_sel_next;

    logic                 slot_we;
    logic [SA_W-1:0]      slot_waddr;
    logic [SA_W-1:0]      slot_raddr;
    logic [7:0]           slot_q;
    logic [FA_W-1:0]      frame_raddr;
    logic [7:0]           frame_q;

    logic [IDX_W-1:0]     idx_l;
    logic [IDX_W-1:0]     cs_l;
    logic                 wr_ok;
    logic [WP_W-1:0]      wp_inc;
    logic                 ovl_eff;
    logic [MAX_FRAGS-1:0] filled_eff;
    logic [CNT_W-1:0]     stored_eff;
    logic [CNT_W-1:0]     exp_eff;
    logic [TOT_W-1:0]     total_eff;
    logic                 check;

    assign idx_l = head.frag_index[IDX_W-1:0];
    assign cs_l  = cs_reg[IDX_W-1:0];
    assign pop   = head_valid && (state_reg == ST_RUN);

    always_comb
    begin
        state_next       = state_reg;
        filled_next      = filled_reg;
        len_next         = len_reg;
        wp_next          = wp_reg;
        ovl_next         = ovl_reg;
        stored_next      = stored_reg;
        expected_next    = expected_reg;
        total_next       = total_reg;
        frame_bytes_next = frame_bytes_reg;
        cs_next          = cs_reg;
        cb_next          = cb_reg;
        pos_next         = pos_reg;
        cp_we_next       = 1'b0;
        cp_addr_next     = pos_reg;
        done_next        = 1'b0;
        stat_next        = stat_reg;
        flen_next        = flen_reg;
        frags_next       = frags_reg;
        rd_sel_next      = 1'b0;
        wr_ok            = wp_reg < WP_W'(MAX_FRAG_BYTES);
        wp_inc           = wr_ok ? (wp_reg + 1'b1) : wp_reg;
        ovl_eff          = ovl_reg | ~wr_ok;
        filled_eff       = head.idx_zero ? '0 : filled_reg;
        stored_eff       = head.idx_zero ? '0 : stored_reg;
        exp_eff          = head.idx_zero ? CNT_W'(head.frag_count) : expected_reg;
        total_eff        = head.idx_zero ? '0 : total_reg;
        check            = 1'b0;
        slot_we          = 1'b0;
        slot_waddr       = SA_W'(idx_l) * SA_W'(MAX_FRAG_BYTES) + SA_W'(wp_reg);
        slot_raddr       = SA_W'(cs_l) * SA_W'(MAX_FRAG_BYTES) + SA_W'(cb_reg);
        frame_raddr      = FA_W'(head.read_offset);

        if (pop && head.is_read)
        begin
            // read of the completed frame
            done_next  = 1'b1;
            flen_next  = 13'(frame_bytes_reg);
            frags_next = stored_reg;
            if (32'(head.read_offset) < 32'(frame_bytes_reg))
            begin
                stat_next   = STAT_READ_OK;
                rd_sel_next = 1'b1;
            end
            else
            begin
                stat_next = STAT_BEYOND;
            end
        end
        else if (pop)
        begin
            // byte write into its slot
            slot_we = wr_ok && head.hdr_ok && (head.idx_zero
                      || (({1'b0, expected_reg} > head.frag_index) && !filled_reg[idx_l]));
            if (!head.last)
            begin
                wp_next  = wp_inc;
                ovl_next = ovl_eff;
            end
            else
            begin
                // judge the whole fragment on its last byte
                wp_next   = '0;
                ovl_next  = 1'b0;
                done_next = 1'b1;
                if (!head.hdr_ok)
                begin
                    stat_next = STAT_BAD_HEADER;
                end
                else
                begin
                    filled_next   = filled_eff;
                    stored_next   = stored_eff;
                    expected_next = exp_eff;
                    total_next    = total_eff;
                    if (head.idx_zero)
                    begin
                        for (int i = 0; i < MAX_FRAGS; i++)
                        begin
                            len_next[i] = '0;
                        end
                    end
                    if ((exp_eff == '0) || ({1'b0, exp_eff} <= head.frag_index))
                    begin
                        stat_next = STAT_NO_FRAME;
                    end
                    else if (filled_eff[idx_l])
                    begin
                        stat_next = STAT_DUPLICATE;
                        check     = 1'b1;
                    end
                    else if (ovl_eff)
                    begin
                        stat_next = STAT_TOO_LONG;
                    end
                    else
                    begin
                        filled_next[idx_l] = 1'b1;
                        len_next[idx_l]    = wp_inc;
                        stored_next        = stored_eff + 1'b1;
                        total_next         = total_eff + TOT_W'(wp_inc);
                        stat_next          = STAT_STORED;
                        check              = 1'b1;
                    end
                    // completion check
                    if (check && (stored_next == exp_eff))
                    begin
                        if (32'(total_next) > 32'(MAX_FRAME_BYTES))
                        begin
                            stat_next = STAT_TOO_LARGE;
                        end
                        else
                        begin
                            stat_next        = STAT_COMPLETE;
                            frame_bytes_next = total_next;
                            state_next       = ST_COPY;
                            cs_next          = '0;
                            cb_next          = '0;
                            pos_next         = '0;
                        end
                    end
                end
                flen_next  = 13'(frame_bytes_next);
                frags_next = (stat_next == STAT_COMPLETE) ? '0 : stored_next;
            end
        end
        else if (state_reg == ST_COPY)
        begin
            // copy slots in index order, one byte a cycle
            if (CNT_W'(cs_reg) == expected_reg)
            begin
                state_next    = ST_RUN;
                filled_next   = '0;
                stored_next   = '0;
                total_next    = '0;
                expected_next = '0;
                for (int i = 0; i < MAX_FRAGS; i++)
                begin
                    len_next[i] = '0;
                end
            end
            else if (cb_reg < len_reg[cs_l])
            begin
                cb_next      = cb_reg + 1'b1;
                pos_next     = pos_reg + 1'b1;
                cp_we_next   = 1'b1;
                cp_addr_next = pos_reg;
            end
            else
            begin
                cs_next = cs_reg + 1'b1;
                cb_next = '0;
            end
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_RUN;
            filled_reg      <= '0;
            wp_reg          <= '0;
            ovl_reg         <= 1'b0;
            stored_reg      <= '0;
            expected_reg    <= '0;
            total_reg       <= '0;
            frame_bytes_reg <= '0;
            cs_reg          <= '0;
            cb_reg          <= '0;
            pos_reg         <= '0;
            cp_we_reg       <= 1'b0;
            done_reg        <= 1'b0;
            rd_sel_reg      <= 1'b0;
            for (int i = 0; i < MAX_FRAGS; i++)
            begin
                len_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg       <= state_next;
            filled_reg      <= filled_next;
            wp_reg          <= wp_next;
            ovl_reg         <= ovl_next;
            stored_reg      <= stored_next;
            expected_reg    <= expected_next;
            total_reg       <= total_next;
            frame_bytes_reg <= frame_bytes_next;
            cs_reg          <= cs_next;
            cb_reg          <= cb_next;
            pos_reg         <= pos_next;
            cp_we_reg       <= cp_we_next;
            done_reg        <= done_next;
            rd_sel_reg      <= rd_sel_next;
            len_reg         <= len_next;
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        cp_addr_reg <= cp_addr_next;
        stat_reg    <= stat_next;
        flen_reg    <= flen_next;
        frags_reg   <= frags_next;
    end

    frb_ram #(.WIDTH(8), .DEPTH(SLOT_DEPTH)) u_slot_ram (
        .clk   (clk),
        .we    (slot_we),
        .waddr (slot_waddr),
        .wdata (head.data_byte),
        .raddr (slot_raddr),
        .rdata (slot_q)
    );

    frb_ram #(.WIDTH(8), .DEPTH(MAX_FRAME_BYTES)) u_frame_ram (
        .clk   (clk),
        .we    (cp_we_reg),
        .waddr (cp_addr_reg),
        .wdata (slot_q),
        .raddr (frame_raddr),
        .rdata (frame_q)
    );

    assign done                = done_reg;
    assign result.status       = stat_reg;
    assign result.frame_length = flen_reg;
    assign result.read_data    = rd_sel_reg ? frame_q : 8'd0;
    assign result.frags_stored = frags_reg;

    `FRB_ASSERT_NEXT(a_result_follows, pop && (head.is_read || head.last), done_reg, "accepted item lost its result")
    `FRB_ASSERT_NEXT(a_partial_silent, pop && !head.is_read && !head.last, !done_reg, "result for a partial fragment byte")
    `FRB_ASSERT(a_stored_bound, stored_reg <= expected_reg, "stored count above expected count")
    `FRB_ASSERT(a_copy_no_write, !(state_reg == ST_COPY && slot_we), "slot written during frame copy")

endmodule

// ===== tb/sv/fragment_reassembly_buffer_tb.sv =====
`timescale 1ns / 100ps

module fragment_reassembly_buffer_tb;
    import frb_pkg::*;

    localparam int CYCLE_LIMIT = 1000000;
    localparam int RANDOM_ITEMS = 200;

    logic clk;
    logic rst_n;
    logic start;
    in_t  cmd;
    logic busy;
    logic done;
    out_t result;

    fragment_reassembly_buffer dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .cmd    (cmd),
        .busy   (busy),
        .done   (done),
        .result (result)
    );

    // predictor state
    logic [7:0] slot_mem [MAX_FRAGS * MAX_FRAG_BYTES];
    int         slot_len [MAX_FRAGS];
    bit         slot_have [MAX_FRAGS];
    int         byte_pos;
    bit         frag_overlong;
    int         have_count;
    int         want_count;
    logic [7:0] frame_mem [MAX_FRAME_BYTES];
    int         frame_len;

    out_t       pending_results [$];
    int         errors;
    int         cycles;
    int         items_sent;

    typedef struct {
        in_t  it;
        bit   typed;
        out_t want;
    } row_t;

    row_t directed [$];

    initial begin
        clk = 1'b0;
    end

    always #5 clk = ~clk;

    // run limit
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    task automatic report(input string field, input int got, input int want_val);
        $display("mismatch %s: got %0d expected %0d at cycle %0d", field, got, want_val, cycles);
        errors++;
    endtask

    function automatic void clear_slots();
        for (int i = 0; i < MAX_FRAGS; i++)
        begin
            slot_len[i] = 0;
            slot_have[i] = 1'b0;
        end
        have_count = 0;
    endfunction

    // join the slots into the frame store once all are filled
    function automatic logic [3:0] try_assemble(input logic [3:0] st);
        int total;
        int pos;
        total = 0;
        pos = 0;
        if (want_count == 0 || have_count < want_count)
            return st;
        for (int i = 0; i < want_count; i++)
        begin
            if (!slot_have[i])
                return st;
            total += slot_len[i];
        end
        if (total > MAX_FRAME_BYTES)
            return STAT_TOO_LARGE;
        for (int i = 0; i < want_count; i++)
            for (int j = 0; j < slot_len[i]; j++)
            begin
                frame_mem[pos] = slot_mem[i * MAX_FRAG_BYTES + j];
                pos++;
            end
        frame_len = total;
        clear_slots();
        want_count = 0;
        return STAT_COMPLETE;
    endfunction

    // expected result of one item, returns 0 when the item gives none
    function automatic bit predict_item(input in_t it, output out_t r);
        int  idx;
        int  cnt;
        bit  hdr;
        r = '0;
        if (it.req_type)
        begin
            if (int'(it.read_offset) < frame_len)
            begin
                r.status = STAT_READ_OK;
                r.read_data = frame_mem[it.read_offset];
            end
            else
                r.status = STAT_BEYOND;
        end
        else
        begin
            idx = it.frag_index;
            cnt = it.frag_count;
            hdr = cnt != 0 && cnt <= MAX_FRAGS && idx < cnt;
            if (byte_pos < MAX_FRAG_BYTES)
            begin
                if (hdr && (idx == 0 || (idx < want_count && !slot_have[idx])))
                    slot_mem[idx * MAX_FRAG_BYTES + byte_pos] = it.data_byte;
                byte_pos++;
            end
            else
                frag_overlong = 1'b1;
            if (!it.byte_last)
                return 1'b0;
            if (!hdr)
                r.status = STAT_BAD_HEADER;
            else
            begin
                if (idx == 0)
                begin
                    clear_slots();
                    want_count = cnt;
                end
                if (want_count == 0 || idx >= want_count)
                    r.status = STAT_NO_FRAME;
                else if (slot_have[idx])
                    r.status = try_assemble(STAT_DUPLICATE);
                else if (frag_overlong)
                    r.status = STAT_TOO_LONG;
                else
                begin
                    slot_have[idx] = 1'b1;
                    slot_len[idx] = byte_pos;
                    have_count++;
                    r.status = try_assemble(STAT_STORED);
                end
            end
            byte_pos = 0;
            frag_overlong = 1'b0;
        end
        r.frame_length = frame_len;
        r.frags_stored = have_count;
        return 1'b1;
    endfunction

    // hand one item to the block and log its expected result
    task automatic send(input in_t it, input bit typed, input out_t typed_out);
        int   gap;
        out_t pred;
        gap = (($urandom % 4) == 0) ? 0 : $urandom_range(0, 9);
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start <= 1'b1;
        cmd <= it;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        if (predict_item(it, pred))
            pending_results.push_back(typed ? typed_out : pred);
        items_sent++;
    endtask

    function automatic in_t frag_item(input int idx, input int cnt, input int b, input bit last);
        in_t it;
        it = '0;
        it.frag_index = idx;
        it.frag_count = cnt;
        it.data_byte = b;
        it.byte_last = last;
        it.read_offset = $urandom_range(0, 4095);
        return it;
    endfunction

    function automatic in_t read_item(input int off);
        in_t it;
        it = '0;
        it.req_type = 1'b1;
        it.read_offset = off;
        it.frag_index = $urandom_range(0, 255);
        it.frag_count = $urandom_range(0, 255);
        it.data_byte = $urandom_range(0, 255);
        it.byte_last = $urandom_range(0, 1);
        return it;
    endfunction

    function automatic row_t mk_row(input in_t it, input int st, input int len,
                                    input int rd, input int stored);
        row_t r;
        r.it = it;
        r.typed = 1'b1;
        r.want = '0;
        r.want.status = st;
        r.want.frame_length = len;
        r.want.read_data = rd;
        r.want.frags_stored = stored;
        return r;
    endfunction

    task automatic send_fragment(input int idx, input int cnt, input int len);
        out_t none;
        none = '0;
        for (int i = 0; i < len; i++)
            send(frag_item(idx, cnt, $urandom_range(0, 255), i == len - 1), 1'b0, none);
    endtask

    // compare each result with the oldest expectation
    always @(posedge clk)
    begin
        out_t w;
        if (rst_n && done === 1'b1)
        begin
            if (pending_results.size() == 0)
            begin
                $display("unexpected result status %0d at cycle %0d", result.status, cycles);
                errors++;
            end
            else
            begin
                w = pending_results.pop_front();
                if (result.status !== w.status)
                    report("status", result.status, w.status);
                if (result.frame_length !== w.frame_length)
                    report("frame_length", result.frame_length, w.frame_length);
                if (result.read_data !== w.read_data)
                    report("read_data", result.read_data, w.read_data);
                if (result.frags_stored !== w.frags_stored)
                    report("frags_stored", result.frags_stored, w.frags_stored);
            end
        end
    end

    initial begin
        out_t none;
        int   cnt;
        int   order [$];
        int   k;
        none = '0;
        errors = 0;
        cycles = 0;
        items_sent = 0;
        start = 1'b0;
        cmd = '0;
        rst_n = 1'b0;
        byte_pos = 0;
        frag_overlong = 1'b0;
        want_count = 0;
        frame_len = 0;
        clear_slots();
        foreach (slot_mem[i]) slot_mem[i] = '0;
        foreach (frame_mem[i]) frame_mem[i] = '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed table: header errors, fragments with no open frame, duplicates, completion, reads
        directed.push_back(mk_row(read_item(0), STAT_BEYOND, 0, 0, 0));
        directed.push_back(mk_row(frag_item(1, 2, 8'h11, 1), STAT_NO_FRAME, 0, 0, 0));
        directed.push_back(mk_row(frag_item(0, 0, 8'h22, 1), STAT_BAD_HEADER, 0, 0, 0));
        directed.push_back(mk_row(frag_item(0, 17, 8'h33, 1), STAT_BAD_HEADER, 0, 0, 0));
        directed.push_back(mk_row(frag_item(2, 2, 8'h44, 1), STAT_BAD_HEADER, 0, 0, 0));
        directed.push_back(mk_row(frag_item(0, 2, 8'hFF, 0), STAT_STORED, 0, 0, 0));
        directed.push_back(mk_row(frag_item(0, 2, 8'h00, 1), STAT_STORED, 0, 0, 1));
        directed.push_back(mk_row(frag_item(1, 2, 8'hA5, 1), STAT_COMPLETE, 3, 0, 0));
        directed.push_back(mk_row(read_item(0), STAT_READ_OK, 3, 8'hFF, 0));
        directed.push_back(mk_row(read_item(1), STAT_READ_OK, 3, 8'h00, 0));
        directed.push_back(mk_row(read_item(2), STAT_READ_OK, 3, 8'hA5, 0));
        directed.push_back(mk_row(read_item(3), STAT_BEYOND, 3, 0, 0));
        directed.push_back(mk_row(read_item(4095), STAT_BEYOND, 3, 0, 0));
        directed.push_back(mk_row(frag_item(0, 16, 8'h5A, 1), STAT_STORED, 3, 0, 1));
        directed.push_back(mk_row(frag_item(15, 16, 8'h01, 1), STAT_STORED, 3, 0, 2));
        directed.push_back(mk_row(frag_item(15, 16, 8'h02, 1), STAT_DUPLICATE, 3, 0, 2));
        directed.push_back(mk_row(frag_item(255, 255, 8'h03, 1), STAT_BAD_HEADER, 3, 0, 2));
        directed.push_back(mk_row(frag_item(3, 3, 8'h04, 1), STAT_BAD_HEADER, 3, 0, 2));
        directed.push_back(mk_row(frag_item(2, 3, 8'h05, 1), STAT_STORED, 3, 0, 3));
        directed.push_back(mk_row(frag_item(0, 1, 8'h80, 1), STAT_COMPLETE, 1, 0, 0));
        directed.push_back(mk_row(read_item(0), STAT_READ_OK, 1, 8'h80, 0));
        foreach (directed[i])
            send(directed[i].it, directed[i].typed, directed[i].want);

        // random frames, mostly well formed, with reads and noise mixed in
        while (items_sent < RANDOM_ITEMS + directed.size())
        begin
            k = $urandom % 10;
            if (k == 0)
                send($urandom, 1'b0, none);
            else if (k == 1)
                send(read_item($urandom_range(0, 4095)), 1'b0, none);
            else if (k == 2)
                send(read_item($urandom_range(0, frame_len + 1)), 1'b0, none);
            else
            begin
                cnt = (($urandom % 8) == 0) ? $urandom_range(1, 16) : $urandom_range(1, 4);
                order.delete();
                for (int i = 1; i < cnt; i++)
                    order.push_back(i);
                order.shuffle();
                if (cnt > 1 && ($urandom % 6) == 0)
                    order.insert($urandom_range(0, order.size()), order[0]);
                if (($urandom % 8) == 0)
                    order.push_back($urandom_range(0, 20));
                send_fragment(0, cnt, $urandom_range(1, 6));
                foreach (order[i])
                begin
                    if (($urandom % 5) == 0)
                        send(read_item($urandom_range(0, frame_len)), 1'b0, none);
                    send_fragment(order[i], cnt, $urandom_range(1, 6));
                end
            end
        end

        // fragment one byte longer than a slot, then the frame completes
        send_fragment(0, 2, 1);
        send_fragment(1, 2, MAX_FRAG_BYTES + 1);
        send_fragment(1, 2, 1);
        send(read_item(0), 1'b0, none);
        send(read_item(1), 1'b0, none);
        send(read_item(4095), 1'b0, none);
        for (int i = 0; i < 3; i++)
            send(read_item($urandom_range(0, 4095)), 1'b0, none);

        // drain
        start <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (200) @(posedge clk);
        if (errors == 0 && pending_results.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+src
src/frb_pkg.sv
src/frb_ram.sv
src/frb_front.sv
src/frb_back.sv
src/fragment_reassembly_buffer.sv
tb/sv/fragment_reassembly_buffer_tb.sv
